// File: hdl/wildcard_glob_matcher_unit_assert.svh
// Assertion macros for the wildcard glob matcher.
`ifndef WILDCARD_GLOB_MATCHER_UNIT_ASSERT_SVH
`define WILDCARD_GLOB_MATCHER_UNIT_ASSERT_SVH

// Checked only while out of reset.
`define WGM_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define WGM_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/wgm_pkg.sv
// Package with shared types and constants of the wildcard glob matcher.
package wgm_pkg;

    // Field widths fixed by the item format.
    localparam int UNIT_W = 16;
    localparam int PLEN_W = 6;
    localparam int PIDX_W = 5;

    // Special pattern units.
    localparam logic [UNIT_W-1:0] UNIT_STAR  = 16'h002A;
    localparam logic [UNIT_W-1:0] UNIT_QMARK = 16'h003F;

    // Item operation codes.
    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_SUBJECT = 2'd1,
        OP_END     = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

endpackage

// File: hdl/wildcard_glob_matcher_unit.sv
// Top level of the wildcard glob matcher: pattern store, position set and result register.
//
//   channel   | handshake             | payload
//   ----------+-----------------------+------------------------------------------
//   input     | in_valid / in_ready   | operation, pattern_index, code_unit
//   result    | out_valid / out_ready | matched
//   config    | pattern_length_we     | pattern_length
//
// One item is taken per cycle unless the input is held; an end item passes through the
// input register and then the result register, which raises out_valid.
// The position update is a single pass of per-position compares plus a log-depth
// prefix chain that closes active positions over runs of '*'.
// Reset clears the position set to position zero and the pattern length to zero;
// the pattern store is not cleared.
// Only an end item waiting on a full, stalled result register holds the input.
module wildcard_glob_matcher_unit
    import wgm_pkg::*;
#(
    parameter int PATTERN_MAX = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          operation,
    input  logic [PIDX_W-1:0]   pattern_index,
    input  logic [UNIT_W-1:0]   code_unit,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                matched,
    input  logic                pattern_length_we,
    input  logic [PLEN_W-1:0]   pattern_length
);

    localparam int NPOS  = PATTERN_MAX + 1;
    localparam int LEN_W = $clog2(NPOS);
    localparam int NLEV  = $clog2(NPOS);

    // Input register.
    logic                in_valid_reg;
    op_t                 op_reg;
    logic [PIDX_W-1:0]   idx_reg;
    logic [UNIT_W-1:0]   unit_reg;

    // Pattern store with decoded wildcard flags.
    logic [UNIT_W-1:0]   store_reg [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] star_reg;
    logic [PATTERN_MAX-1:0] qmark_reg;

    // Configuration and matcher state.
    logic [PLEN_W-1:0]   pattern_length_reg;
    logic [NPOS-1:0]     active_reg;
    logic [NPOS-1:0]     active_next;
    logic                out_valid_reg;
    logic                matched_reg;

    logic                advance;
    logic                is_end;
    logic [LEN_W-1:0]    used_len;
    logic [PATTERN_MAX-1:0] use_mask;
    logic [PATTERN_MAX-1:0] hit;
    logic [NPOS-1:0]     closed;
    logic [NPOS-1:0]     gen_lvl  [NLEV+1];
    logic [NPOS-1:0]     prop_lvl [NLEV+1];

    // Stage two moves unless an end item finds the result register full and stalled.
    assign is_end   = (op_reg == OP_END);
    assign advance  = in_valid_reg && (!is_end || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Length in use, capped at the store depth.
    always_comb
    begin
        if (32'(pattern_length_reg) > PATTERN_MAX)
        begin
            used_len = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            used_len = LEN_W'(pattern_length_reg);
        end
    end

    // Per-position flags: position in use, and subject unit accepted there.
    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            use_mask[i] = (32'(used_len) > i);
            hit[i]      = qmark_reg[i] || (store_reg[i] == unit_reg);
        end
    end

    // Star closure as a parallel prefix: position j+1 turns on when j is active
    // and holds an in-use '*'.
    always_comb
    begin
        gen_lvl[0]     = active_reg;
        prop_lvl[0][0] = 1'b0;
        for (int j = 1; j < NPOS; j++)
        begin
            prop_lvl[0][j] = star_reg[j-1] && use_mask[j-1];
        end
        for (int k = 0; k < NLEV; k++)
        begin
            for (int j = 0; j < NPOS; j++)
            begin
                if (j >= (1 << k))
                begin
                    gen_lvl[k+1][j]  = gen_lvl[k][j]
                                     || (prop_lvl[k][j] && gen_lvl[k][j-(1<<k)]);
                    prop_lvl[k+1][j] = prop_lvl[k][j] && prop_lvl[k][j-(1<<k)];
                end
                else
                begin
                    gen_lvl[k+1][j]  = gen_lvl[k][j];
                    prop_lvl[k+1][j] = prop_lvl[k][j];
                end
            end
        end
        closed = gen_lvl[NLEV];
    end

    // Next position set for a subject unit: '*' holds its place, a match steps on.
    always_comb
    begin
        for (int j = 0; j < NPOS; j++)
        begin
            active_next[j] = 1'b0;
            if (j < PATTERN_MAX)
            begin
                if (closed[j] && use_mask[j] && star_reg[j])
                begin
                    active_next[j] = 1'b1;
                end
            end
            if (j >= 1)
            begin
                if (closed[j-1] && use_mask[j-1] && !star_reg[j-1] && hit[j-1])
                begin
                    active_next[j] = 1'b1;
                end
            end
        end
    end

    // Input register takes a transfer whenever stage two is free or moving.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg   <= op_t'(operation);
            idx_reg  <= pattern_index;
            unit_reg <= code_unit;
        end
    end

    // Pattern loads; indexes beyond the store are dropped.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (advance && (op_reg == OP_LOAD) && (32'(idx_reg) == i))
            begin
                store_reg[i] <= unit_reg;
                star_reg[i]  <= (unit_reg == UNIT_STAR);
                qmark_reg[i] <= (unit_reg == UNIT_QMARK);
            end
        end
    end

    // Pattern length register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
        end
        else if (pattern_length_we)
        begin
            pattern_length_reg <= pattern_length;
        end
    end

    // Position set: stepped by subject units, rearmed by end items.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= NPOS'(1);
        end
        else if (advance)
        begin
            case (op_reg)
                OP_SUBJECT:
                begin
                    active_reg <= active_next;
                end
                OP_END:
                begin
                    active_reg <= NPOS'(1);
                end
                default:
                begin
                    active_reg <= active_reg;
                end
            endcase
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && is_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_end)
        begin
            matched_reg <= closed[used_len];
        end
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;

    // Assertions.
    `include "wildcard_glob_matcher_unit_assert.svh"

    `WGM_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_reg && !in_valid_reg,
        "pipeline not empty in reset")
    `WGM_ASSERT(a_end_rearms, advance && is_end |=> active_reg == NPOS'(1),
        "end item did not rearm")
    `WGM_ASSERT(a_load_keeps_state, advance && op_reg == OP_LOAD |=> $stable(active_reg),
        "load changed positions")
    `WGM_ASSERT(a_stall_cause,
        !in_ready |-> in_valid_reg && is_end && out_valid_reg && !out_ready,
        "input held without a stalled result")
    `WGM_ASSERT(a_result_source, $rose(out_valid_reg) |-> $past(advance && is_end),
        "result without an end item")

endmodule

// File: verif/wildcard_glob_matcher_unit_tb.sv
// Self-checking testbench for the wildcard glob matcher: random items, stalls and length changes.
module wildcard_glob_matcher_unit_tb;
    import wgm_pkg::*;

    localparam int PATTERN_MAX = 32;
    localparam int ITEM_TARGET = 1600;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 200;
    localparam logic [UNIT_W-1:0] UNIT_A = 16'h0061;

    // Tracks the pattern, the set of live positions and the match results still owed.
    class glob_scoreboard;
        logic [UNIT_W-1:0] store [PATTERN_MAX];
        bit [PATTERN_MAX:0] live;
        logic [PLEN_W-1:0] plen;
        bit pending_matches [$];
        int errors;

        function new();
            foreach (store[i])
                store[i] = '0;
            live = (PATTERN_MAX+1)'(1);
            plen = '0;
            errors = 0;
        endfunction

        function void set_length(logic [PLEN_W-1:0] v);
            plen = v;
        endfunction

        // Lengths beyond the store size use the whole store.
        function int used_len();
            if (plen > PATTERN_MAX)
                return PATTERN_MAX;
            return int'(plen);
        endfunction

        // A live star also makes the position after it live.
        function void close_stars(int n);
            for (int i = 0; i < n; i++)
            begin
                if (live[i] && store[i] == UNIT_STAR)
                    live[i+1] = 1'b1;
            end
        endfunction

        // Advances the match state by one transferred input item.
        function void note_item(op_t op, logic [PIDX_W-1:0] idx, logic [UNIT_W-1:0] unit);
            int n;
            bit [PATTERN_MAX:0] nxt;
            n = used_len();
            case (op)
                OP_LOAD:
                    store[idx] = unit;
                OP_SUBJECT:
                begin
                    close_stars(n);
                    nxt = '0;
                    for (int i = 0; i < n; i++)
                    begin
                        if (live[i])
                        begin
                            if (store[i] == UNIT_STAR)
                                nxt[i] = 1'b1;
                            else if (store[i] == UNIT_QMARK || store[i] == unit)
                                nxt[i+1] = 1'b1;
                        end
                    end
                    live = nxt;
                end
                OP_END:
                begin
                    close_stars(n);
                    pending_matches = {pending_matches, live[n]};
                    live = (PATTERN_MAX+1)'(1);
                end
                default: ;
            endcase
        endfunction

        // Compares one transferred result with the oldest owed match bit.
        function void check_matched(logic got);
            bit want;
            if (pending_matches.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual matched=%b", $time, got);
                errors++;
                return;
            end
            want = pending_matches.pop_front();
            if (got !== want)
            begin
                $display("%0t: matched mismatch, expected %b, actual %b", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [1:0] operation;
    logic [PIDX_W-1:0] pattern_index;
    logic [UNIT_W-1:0] code_unit;
    logic out_valid;
    logic out_ready;
    logic matched;
    logic pattern_length_we;
    logic [PLEN_W-1:0] pattern_length;

    glob_scoreboard sb = new();
    logic [UNIT_W-1:0] pattern_img [PATTERN_MAX];
    bit hold_req;
    bit tx_quiet;
    int items_sent;

    wildcard_glob_matcher_unit #(.PATTERN_MAX(PATTERN_MAX)) dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .pattern_index(pattern_index),
        .code_unit(code_unit),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .matched(matched),
        .pattern_length_we(pattern_length_we),
        .pattern_length(pattern_length)
    );

    always #10 clk = ~clk;

    // Run limit in case the block hangs.
    initial
    begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

    // Watch both channels; results are checked before the new item is noted.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_matched(matched);
        if (rst_n && in_valid && in_ready)
            sb.note_item(op_t'(operation), pattern_index, code_unit);
    end

    // Result side: random stalls, quiet stretches and one long hold on request.
    initial
    begin
        int gap_left;
        bit quiet;
        int r;
        out_ready = 1'b0;
        gap_left = 0;
        quiet = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            if ($urandom_range(0, 399) == 0)
                quiet = !quiet;
            if (gap_left > 0)
            begin
                out_ready <= 1'b0;
                gap_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 4) == 0)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 80)
                        gap_left = $urandom_range(1, 3);
                    else if (r < 95)
                        gap_left = $urandom_range(4, 10);
                    else
                        gap_left = $urandom_range(15, 40);
                end
            end
        end
    end

    // Idle cycles before the next input transfer: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        if (tx_quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    function automatic logic [UNIT_W-1:0] pattern_unit();
        int r;
        r = $urandom_range(0, 19);
        if (r < 4)
            return UNIT_STAR;
        if (r < 7)
            return UNIT_QMARK;
        if (r < 17)
            return UNIT_A + 16'($urandom_range(0, 2));
        if (r == 17)
            return '0;
        return 16'($urandom);
    endfunction

    function automatic logic [UNIT_W-1:0] subject_unit();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return UNIT_A + 16'($urandom_range(0, 2));
        if (r == 12)
            return UNIT_STAR;
        if (r == 13)
            return UNIT_QMARK;
        if (r == 14)
            return '0;
        if (r == 15)
            return '1;
        return 16'($urandom);
    endfunction

    // Offers one item and returns at the edge where it is transferred.
    task automatic send_item(input op_t op, input logic [PIDX_W-1:0] idx,
                             input logic [UNIT_W-1:0] unit);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        pattern_index <= idx;
        code_unit <= unit;
        do
            @(posedge clk);
        while (!in_ready);
        if (op != OP_NONE)
            items_sent++;
    endtask

    // Stops offering until every owed result is in and the pipeline has emptied.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [PLEN_W-1:0] v);
        pattern_length_we <= 1'b1;
        pattern_length <= v;
        @(posedge clk);
        sb.set_length(v);
        pattern_length_we <= 1'b0;
    endtask

    task automatic load_unit(input logic [PIDX_W-1:0] idx, input logic [UNIT_W-1:0] unit);
        pattern_img[idx] = unit;
        send_item(OP_LOAD, idx, unit);
    endtask

    // Streams a subject and its end item, optionally with loads and dead items mixed in.
    task automatic run_subject(input logic [UNIT_W-1:0] units [$], input bit mix);
        foreach (units[i])
        begin
            if (mix && $urandom_range(0, 15) == 0)
            begin
                if ($urandom_range(0, 2) == 0)
                    send_item(OP_NONE, PIDX_W'($urandom), 16'($urandom));
                else
                    load_unit(PIDX_W'($urandom), pattern_unit());
            end
            send_item(OP_SUBJECT, PIDX_W'($urandom), units[i]);
        end
        send_item(OP_END, PIDX_W'($urandom), 16'($urandom));
    endtask

    // Mostly subjects built to fit the current pattern, some mutated, some pure noise.
    task automatic random_subject(input int n);
        logic [UNIT_W-1:0] units [$];
        int r;
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(0, 6)) units = {units, subject_unit()};
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                if (pattern_img[i] == UNIT_STAR)
                    repeat ($urandom_range(0, 2)) units = {units, subject_unit()};
                else if (pattern_img[i] == UNIT_QMARK)
                    units = {units, subject_unit()};
                else
                    units = {units, pattern_img[i]};
            end
            if (units.size() > 0 && $urandom_range(0, 4) == 0)
            begin
                r = $urandom_range(0, units.size() - 1);
                units[r] = subject_unit();
            end
        end
        run_subject(units, 1'b1);
    endtask

    // One setting of the length register, a fresh pattern and a batch of subjects.
    task automatic random_phase(input int phase);
        logic [PLEN_W-1:0] len;
        int n;
        int r;
        case (phase)
            0: len = 6'd32;
            1: len = 6'd63;
            2: len = 6'd1;
            3: len = 6'd33;
            4: len = 6'd0;
            default:
            begin
                r = $urandom_range(0, 15);
                if (r == 0)
                    len = 6'd0;
                else if (r == 1)
                    len = 6'd32;
                else if (r == 2)
                    len = PLEN_W'($urandom_range(33, 63));
                else
                    len = PLEN_W'($urandom_range(1, 10));
            end
        endcase
        n = (len > PATTERN_MAX) ? PATTERN_MAX : int'(len);
        drain();
        write_length(len);
        tx_quiet = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++)
            load_unit(PIDX_W'(i), pattern_unit());
        repeat ($urandom_range(0, 2)) load_unit(PIDX_W'($urandom), pattern_unit());
        repeat ($urandom_range(3, 10)) random_subject(n);
        tx_quiet = 1'b0;
    endtask

    initial
    begin
        logic [UNIT_W-1:0] units [$];
        int phase;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_LOAD;
        pattern_index = '0;
        code_unit = '0;
        pattern_length_we = 1'b0;
        pattern_length = '0;
        hold_req = 1'b0;
        tx_quiet = 1'b0;
        items_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty pattern: only an empty subject matches; a dead item after them.
        send_item(OP_END, '0, '0);
        send_item(OP_SUBJECT, '1, '1);
        send_item(OP_END, '1, '1);
        send_item(OP_NONE, '1, '1);

        // Pattern of a zero unit, a question mark and a star.
        drain();
        write_length(6'd3);
        load_unit(5'd0, '0);
        load_unit(5'd1, UNIT_QMARK);
        load_unit(5'd2, UNIT_STAR);
        units = '{16'h0000, 16'hFFFF};
        run_subject(units, 1'b0);
        units = '{16'h0000, UNIT_STAR, UNIT_STAR, UNIT_STAR};
        run_subject(units, 1'b0);
        units = {};
        run_subject(units, 1'b0);

        // All stars: the empty subject matches, and a star in the subject too.
        load_unit(5'd0, UNIT_STAR);
        load_unit(5'd1, UNIT_STAR);
        run_subject(units, 1'b0);
        units = '{UNIT_STAR};
        run_subject(units, 1'b0);

        // Random phases, with one long result-side hold after the first one.
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            random_phase(phase);
            if (phase == 0)
            begin
                drain();
                tx_quiet = 1'b1;
                hold_req = 1'b1;
                units = '{UNIT_A};
                repeat (30) run_subject(units, 1'b0);
                tx_quiet = 1'b0;
            end
            phase++;
        end
        drain();

        if (sb.errors == 0 && sb.pending_matches.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// File: wildcard_glob_matcher_unit.f
+incdir+hdl
hdl/wgm_pkg.sv
hdl/wildcard_glob_matcher_unit.sv
verif/wildcard_glob_matcher_unit_tb.sv
